// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int IN_W   = 63;
    localparam int CNT_W  = 6;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 2;

    localparam logic [DATA_W-1:0] MOD_RESET      = 32'd1000000007;
    localparam logic [ADDR_W-1:0] REG_MODULUS_AD = 2'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_BASE_DONE,
        S_SQUARE,
        S_SQ_DONE,
        S_MULT,
        S_MUL_DONE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
    } t_mm_ctl;

endpackage

// ===== rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// base^exponent mod modulus by left-to-right square-and-multiply. the base is
// first reduced one bit per cycle, then each of the 63 exponent bits costs a
// squaring and, for a set bit, a multiply, each done by the bit-serial modular
// multiply-add in mexp_mulmod at one multiplier bit per cycle, followed by a
// turnaround state. an exponent of zero returns exactly 1.
// one item is worked on at a time; the result sits in an output register so
// the next item is taken while it waits. a modulus of zero acts as
// 2^MODULUS_BITS; change the modulus only with no item in flight.
module modular_exponentiation #(
    parameter int MODULUS_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mexp_pkg::IN_W-1:0]       i_base_value,
    input  logic [mexp_pkg::IN_W-1:0]       i_exponent,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mexp_pkg::DATA_W-1:0]     o_power_result,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [mexp_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [mexp_pkg::DATA_W-1:0]     i_pwdata,
    output logic [mexp_pkg::DATA_W-1:0]     o_prdata,
    output logic                            o_pready
);
    import mexp_pkg::*;

    localparam int N = MODULUS_BITS;

    t_state                r_state, n_state;
    logic [DATA_W-1:0]     r_modulus;
    logic [IN_W-1:0]       r_src, n_src;
    logic [IN_W-1:0]       r_exp, n_exp;
    logic [N-1:0]          r_mplr, n_mplr;
    logic [N-1:0]          r_res, n_res;
    logic [N-1:0]          r_base, n_base;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_bit, n_bit;
    logic [N-1:0]          r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [N:0]            w_mod_eff;
    logic [N-1:0]          w_addend;
    logic [N-1:0]          w_acc;
    t_mm_ctl               w_ctl;
    logic                  w_wr;

    assign w_mod_eff = {(r_modulus[N-1:0] == '0), r_modulus[N-1:0]};

    mexp_mulmod #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_modulus(w_mod_eff),
        .i_addend (w_addend),
        .o_acc    (w_acc)
    );

    // config port
    assign w_wr     = i_psel && i_penable && i_pwrite && (i_paddr == REG_MODULUS_AD);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == REG_MODULUS_AD) ? r_modulus : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (w_wr) begin
            r_modulus <= i_pwdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_exp       = r_exp;
        n_mplr      = r_mplr;
        n_res       = r_res;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        w_ctl       = '0;
        w_addend    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res = N'(1);
                    if (i_exponent == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_src       = i_base_value;
                        n_exp       = i_exponent;
                        n_cnt       = '0;
                        n_bit       = '0;
                        w_ctl.clear = 1'b1;
                        n_state     = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                w_addend   = N'(r_src[IN_W-1]);
                w_ctl.step = 1'b1;
                n_src      = {r_src[IN_W-2:0], 1'b0};
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(IN_W - 1)) begin
                    n_state = S_BASE_DONE;
                end
            end
            S_BASE_DONE: begin
                n_base      = w_acc;
                n_mplr      = r_res;
                n_cnt       = '0;
                w_ctl.clear = 1'b1;
                n_state     = S_SQUARE;
            end
            S_SQUARE: begin
                w_addend   = r_mplr[N-1] ? r_res : '0;
                w_ctl.step = 1'b1;
                n_mplr     = {r_mplr[N-2:0], 1'b0};
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N - 1)) begin
                    n_state = S_SQ_DONE;
                end
            end
            S_SQ_DONE: begin
                n_res       = w_acc;
                n_cnt       = '0;
                w_ctl.clear = 1'b1;
                if (r_exp[IN_W-1]) begin
                    n_mplr  = r_base;
                    n_state = S_MULT;
                end else begin
                    n_exp  = {r_exp[IN_W-2:0], 1'b0};
                    n_bit  = r_bit + 1'b1;
                    n_mplr = w_acc;
                    if (r_bit == CNT_W'(IN_W - 1)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SQUARE;
                    end
                end
            end
            S_MULT: begin
                w_addend   = r_mplr[N-1] ? r_res : '0;
                w_ctl.step = 1'b1;
                n_mplr     = {r_mplr[N-2:0], 1'b0};
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N - 1)) begin
                    n_state = S_MUL_DONE;
                end
            end
            S_MUL_DONE: begin
                n_res       = w_acc;
                n_cnt       = '0;
                w_ctl.clear = 1'b1;
                n_exp       = {r_exp[IN_W-2:0], 1'b0};
                n_bit       = r_bit + 1'b1;
                n_mplr      = w_acc;
                if (r_bit == CNT_W'(IN_W - 1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SQUARE;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_exp  <= n_exp;
        r_mplr <= n_mplr;
        r_res  <= n_res;
        r_base <= n_base;
        r_cnt  <= n_cnt;
        r_bit  <= n_bit;
        r_out  <= n_out;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_power_result = DATA_W'(r_out);

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((N + 1)'(r_out) < w_mod_eff) || (r_out == N'(1)))
        else $error("result not reduced");

    a_mult_on_set_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULT) |-> r_exp[IN_W-1])
        else $error("multiply on clear exponent bit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("item taken while busy");

endmodule

// ===== rtl/mexp_mulmod.sv =====
`timescale 1ns / 1ps

module mexp_mulmod #(
    parameter int MODULUS_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mexp_pkg::t_mm_ctl       i_ctl,
    input  logic [MODULUS_BITS:0]   i_modulus,
    input  logic [MODULUS_BITS-1:0] i_addend,
    output logic [MODULUS_BITS-1:0] o_acc
);
    import mexp_pkg::*;

    localparam int W = MODULUS_BITS + 2;

    logic [MODULUS_BITS-1:0] r_acc;
    logic [MODULUS_BITS-1:0] n_acc;
    logic [W-1:0]            w_sum;
    logic [W-1:0]            w_m1;
    logic [W-1:0]            w_m2;
    logic [W-1:0]            w_red;

    // acc <- (2*acc + addend) mod m, sum stays below 3m
    assign w_sum = W'({r_acc, 1'b0}) + W'(i_addend);
    assign w_m1  = W'(i_modulus);
    assign w_m2  = {i_modulus, 1'b0};

    always_comb begin
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            n_acc = w_red[MODULUS_BITS-1:0];
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && !i_ctl.clear |=> W'(r_acc) < W'(i_modulus))
        else $error("accumulator not reduced");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> r_acc == '0)
        else $error("accumulator not cleared");

endmodule

// ===== tb/sv/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    import mexp_pkg::*;

    localparam int  RAND_PHASES     = 7;
    localparam int  ITEMS_PER_PHASE = 17;
    localparam int  PRESSURE_PHASE  = 4;
    localparam int  PRESSURE_CYCLES = 12000;
    localparam int  DRAIN_CYCLES    = 16;
    localparam int  CYCLE_LIMIT     = 3000000;

    localparam logic [IN_W-1:0]   IN_MAX = {IN_W{1'b1}};
    localparam logic [DATA_W-1:0] MOD_ONE = 32'd1;
    localparam logic [DATA_W-1:0] MOD_ZERO = 32'd0;
    localparam logic [DATA_W-1:0] MOD_MAX = 32'hFFFF_FFFF;

    // holds the expected powers and the current modulus
    class powmod_scoreboard;
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] power_q[$];
        int                errors;

        function new();
            modulus = MOD_RESET;
            errors  = 0;
        endfunction

        function logic [DATA_W-1:0] powmod(logic [IN_W-1:0] b, logic [IN_W-1:0] e);
            logic [63:0] m;
            logic [63:0] acc;
            logic [63:0] rb;
            if (e == '0)
                return DATA_W'(1);
            m   = (modulus == '0) ? 64'h1_0000_0000 : {32'd0, modulus};
            rb  = {1'b0, b} % m;
            acc = 64'd1;
            for (int k = IN_W - 1; k >= 0; k--) begin
                acc = (acc * acc) % m;
                if (e[k])
                    acc = (acc * rb) % m;
            end
            return acc[DATA_W-1:0];
        endfunction

        function void note_input(logic [IN_W-1:0] b, logic [IN_W-1:0] e);
            power_q = {power_q, powmod(b, e)};
        endfunction

        function void check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (power_q.size() == 0) begin
                $error("power_result: unexpected item, expected none got %0d", got);
                errors++;
            end else begin
                want = power_q.pop_front();
                if (got !== want) begin
                    $error("power_result: expected %0d got %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return power_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [IN_W-1:0]      i_base_value = '0;
    logic [IN_W-1:0]      i_exponent = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [DATA_W-1:0]    o_power_result;
    logic                 i_psel = 1'b0;
    logic                 i_penable = 1'b0;
    logic                 i_pwrite = 1'b0;
    logic [ADDR_W-1:0]    i_paddr = '0;
    logic [DATA_W-1:0]    i_pwdata = '0;
    logic [DATA_W-1:0]    o_prdata;
    logic                 o_pready;

    powmod_scoreboard sb = new();
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    int               hold_left = 0;
    int               cycle_count = 0;

    modular_exponentiation DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_power_result (o_power_result),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_pready       (o_pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side, with a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (rx_stall_pct > 0) begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_power_result);
    end

    function automatic logic [IN_W-1:0] rand_in();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[IN_W-1:0];
    endfunction

    task automatic send_item(input logic [IN_W-1:0] b, input logic [IN_W-1:0] e);
        @(negedge i_clk);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_base_value <= b;
        i_exponent   <= e;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_input(b, e);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    // write, then read back, the modulus register
    task automatic write_modulus(input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= REG_MODULUS_AD;
        i_pwdata  <= value;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(negedge i_clk);
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        if (o_prdata !== value) begin
            $error("modulus readback: expected %0d got %0d", value, o_prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        sb.modulus = value;
    endtask

    task automatic send_random(input int n);
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] e;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: b = '0;
                1: b = IN_W'($urandom_range(3));
                2: b = {31'd0, sb.modulus};
                3: b = {31'd0, sb.modulus} - 1'b1;
                4: b = IN_MAX;
                default: b = rand_in();
            endcase
            case ($urandom_range(9))
                0: e = '0;
                1: e = IN_W'($urandom_range(16, 1));
                2: e = IN_W'(1) << $urandom_range(IN_W - 1);
                3: e = IN_MAX;
                4: e = rand_in() >> $urandom_range(IN_W - 1);
                default: e = rand_in();
            endcase
            send_item(b, e);
        end
        end_stream();
    endtask

    initial begin
        logic [DATA_W-1:0] phase_mod[RAND_PHASES];

        phase_mod = '{MOD_MAX, 32'd2, 32'd97, $urandom, MOD_RESET, $urandom, 32'd3};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus: extremes, fermat, exact multiples
        send_item('0, '0);
        send_item('0, IN_W'(1));
        send_item(IN_W'(1), '0);
        send_item(IN_MAX, '0);
        send_item(IN_MAX, IN_W'(1));
        send_item(IN_MAX, IN_MAX);
        send_item(IN_W'(2), IN_MAX);
        send_item(IN_W'(MOD_RESET), IN_W'(5));
        send_item(IN_W'(MOD_RESET) - 1'b1, IN_W'(2));
        send_item(IN_W'(MOD_RESET) - 1'b1, IN_W'(1) << (IN_W - 1));
        send_item(IN_W'(3), IN_W'(MOD_RESET) - 1'b1);
        send_item(IN_MAX, IN_W'(2));
        end_stream();
        wait_drain();

        // modulus one: zero exponent still gives one
        write_modulus(MOD_ONE);
        send_item(IN_W'(5), '0);
        send_item(IN_W'(5), IN_W'(7));
        send_item('0, '0);
        send_item(IN_MAX, IN_MAX);
        end_stream();
        wait_drain();

        // modulus zero acts as 2^32
        write_modulus(MOD_ZERO);
        send_item(IN_W'(2), IN_W'(31));
        send_item(IN_W'(2), IN_W'(32));
        send_item(IN_MAX, IN_MAX);
        send_item(IN_W'(3), '0);
        send_item(IN_W'(MOD_MAX), IN_W'(2));
        end_stream();
        wait_drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_modulus(phase_mod[ph]);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            if (ph == PRESSURE_PHASE)
                hold_left = PRESSURE_CYCLES;
            send_random(ITEMS_PER_PHASE);
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
